// ===== hw/rtl/packed_word_sample_unpacker_core_defines.svh =====
// Assertion macros shared by the sample unpacker RTL.
// Relies on clk and rst being in scope in the module that uses them.
`ifndef PACKED_WORD_SAMPLE_UNPACKER_CORE_DEFINES_SVH
`define PACKED_WORD_SAMPLE_UNPACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// condition must hold on every clock out of reset
`define PWSU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PWSU_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define PWSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PWSU_ASSERT_ALWAYS(label, cond, msg)
`define PWSU_ASSERT_IMPLIES(label, ante, cons, msg)
`define PWSU_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/pwsu_pkg.sv =====
// Package for the packed word sample unpacker: widths, register indexes, types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pwsu_pkg;

  localparam int IN_W              = 32;
  localparam int OUT_W             = 32;
  localparam int BPS_W             = 6;
  localparam int SPL_W             = 16;
  localparam int MAX_SAMPLE_BITS   = 32;
  localparam int MAX_RESULTS       = 32;
  localparam int CNT_W             = 5;
  localparam int AVAIL_W           = 7;   // holds a bit pointer up to 64
  localparam int WORD_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH       = 2;
  localparam int QPTR_W            = 1;
  localparam int QCNT_W            = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_SAMPLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_LINE = 2'd2;

  localparam logic [BPS_W-1:0] BPS_RESET = 6'd10;
  localparam logic [SPL_W-1:0] SPL_RESET = 16'd3;

  typedef struct packed {
    logic [BPS_W-1:0] bits_per_sample;
    logic             pad_mode;
    logic [SPL_W-1:0] samples_per_line;
  } pwsu_cfg_t;

  // per-word control carried through the queue
  typedef struct packed {
    logic [AVAIL_W-1:0] avail;
    logic [BPS_W-1:0]   bps;
  } pwsu_ctl_t;

endpackage

// ===== hw/rtl/pwsu_front.sv =====
// Front end: accepts packed words, drops those with an unusable sample width,
// works out the usable bit span and queues the word. Depends on pwsu_pkg.
`timescale 1ns / 1ps
`include "packed_word_sample_unpacker_core_defines.svh"

module pwsu_front
  import pwsu_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pwsu_cfg_t            cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_W-1:0]      packed_word,
  output logic                 q_valid,
  input  logic                 q_pop,
  output logic [WORD_BITS-1:0] q_word,
  output pwsu_ctl_t            q_ctl
);

  localparam int TAB_N = 2 ** BPS_W;

  // usable span below the top pad, one entry per sample width
  logic [AVAIL_W-1:0] avail_pad [TAB_N];

  assign avail_pad[0] = '0;
  for (genvar g = 1; g < TAB_N; g++) begin : g_pad
    localparam int PadBits = WORD_BITS % g;
    assign avail_pad[g] = AVAIL_W'(WORD_BITS - PadBits);
  end

  logic               bps_ok;
  logic [AVAIL_W-1:0] avail_sel;
  logic [WORD_BITS-1:0] word_in;
  logic               push;

  // classify: width zero, above 32 or above the word means no samples
  assign bps_ok = (cfg.bits_per_sample != '0)
               && (cfg.bits_per_sample <= BPS_W'(MAX_SAMPLE_BITS))
               && ({1'b0, cfg.bits_per_sample} <= AVAIL_W'(WORD_BITS));

  assign avail_sel = cfg.pad_mode ? avail_pad[cfg.bits_per_sample]
                                  : AVAIL_W'(WORD_BITS);

  assign word_in = WORD_BITS'({{WORD_BITS{1'b0}}, packed_word});

  // two-entry queue
  logic [WORD_BITS-1:0] q_word_mem [QUEUE_DEPTH];
  pwsu_ctl_t            q_ctl_mem  [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QCNT_W-1:0]    count;

  assign in_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall && bps_ok;
  assign q_valid  = (count != '0);
  assign q_word   = q_word_mem[rd_ptr];
  assign q_ctl    = q_ctl_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_word_mem[wr_ptr]    <= word_in;
      q_ctl_mem[wr_ptr]     <= '{avail: avail_sel, bps: cfg.bits_per_sample};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      priority case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `PWSU_ASSERT_ALWAYS(a_count_range, count <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")
  `PWSU_ASSERT_IMPLIES(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")
  `PWSU_ASSERT_NEXT(a_push_visible, push, q_valid, "pushed word not visible")

endmodule

// ===== hw/rtl/pwsu_back.sv =====
// Back end: steps through the queued word one sample per cycle unless stalled, tracks the
// line position and holds the result in an output register. Depends on pwsu_pkg.
`timescale 1ns / 1ps
`include "packed_word_sample_unpacker_core_defines.svh"

module pwsu_back
  import pwsu_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pwsu_cfg_t            cfg,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  logic [WORD_BITS-1:0] q_word,
  input  pwsu_ctl_t            q_ctl,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     sample_value,
  output logic                 last_of_word,
  output logic                 end_of_line
);

  // word being unpacked
  logic                 cur_valid;
  logic [WORD_BITS-1:0] cur_word;
  logic [AVAIL_W-1:0]   cur_ptr;
  logic [BPS_W-1:0]     cur_bps;
  logic [CNT_W-1:0]     cur_n;
  logic [SPL_W-1:0]     line_pos;

  logic                 out_free;
  logic                 emit;
  logic [AVAIL_W-1:0]   ptr_next;
  logic [WORD_BITS-1:0] shifted;
  logic [OUT_W-1:0]     smask;
  logic [OUT_W-1:0]     sample;
  logic [SPL_W:0]       line_len;
  logic [SPL_W:0]       pos_inc;
  logic                 eol;
  logic                 last;

  assign out_free = !out_valid || !out_stall;
  assign emit     = cur_valid && out_free;

  // sample extraction from the top of the remaining span
  assign ptr_next = cur_ptr - AVAIL_W'(cur_bps);
  assign shifted  = cur_word >> ptr_next;
  assign smask    = OUT_W'(({{OUT_W{1'b0}}, 1'b1} << cur_bps) - 1'b1);
  assign sample   = OUT_W'({{OUT_W{1'b0}}, shifted}) & smask;

  // line length zero means a full 65536-sample line
  assign line_len = (cfg.samples_per_line == '0) ? {1'b1, {SPL_W{1'b0}}}
                                                 : {1'b0, cfg.samples_per_line};
  assign pos_inc  = {1'b0, line_pos} + 1'b1;
  assign eol      = (pos_inc >= line_len);
  assign last     = eol || (ptr_next < AVAIL_W'(cur_bps))
                 || (cur_n == CNT_W'(MAX_RESULTS - 1));

  assign q_pop = q_valid && (!cur_valid || (emit && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_n     <= '0;
      line_pos  <= '0;
    end else begin
      if (emit) begin
        line_pos <= eol ? '0 : pos_inc[SPL_W-1:0];
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        cur_n     <= '0;
      end else if (emit) begin
        cur_valid <= !last;
        cur_n     <= cur_n + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_word <= q_word;
      cur_ptr  <= q_ctl.avail;
      cur_bps  <= q_ctl.bps;
    end else if (emit) begin
      cur_ptr  <= ptr_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sample_value <= sample;
      last_of_word <= last;
      end_of_line  <= eol;
    end
  end

  `PWSU_ASSERT_IMPLIES(a_ptr_covers, cur_valid, cur_ptr >= AVAIL_W'(cur_bps), "pointer below width")
  `PWSU_ASSERT_NEXT(a_eol_resets_pos, emit && eol, line_pos == '0, "line position not cleared")
  `PWSU_ASSERT_NEXT(a_word_continues, emit && !last, cur_valid, "word dropped before last sample")

endmodule

// ===== hw/rtl/packed_word_sample_unpacker_core.sv =====
// Top level of the packed word sample unpacker: configuration registers,
// front end and back end. Depends on pwsu_pkg, pwsu_front and pwsu_back.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall  packed_word
//   out       source     out_valid/out_stall  sample_value, last_of_word, end_of_line
//   cfg       sink       cfg_we               cfg_index, cfg_data
//
// One sample leaves per cycle while the output is not stalled; the samples of a word
// are extracted one after another by the single extraction shifter. Words are taken
// every cycle while the two-entry queue has room.
// A word with an unusable sample width is taken and dropped without entering the queue.
// Reset is synchronous and clears queue, sequencer, line counter and output valid.
// A stall on the output holds the result; the queue absorbs input meanwhile.
`timescale 1ns / 1ps

module packed_word_sample_unpacker_core
  import pwsu_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IN_W-1:0]       packed_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      sample_value,
  output logic                  last_of_word,
  output logic                  end_of_line
);

  pwsu_cfg_t            cfg;
  logic                 q_valid;
  logic                 q_pop;
  logic [WORD_BITS-1:0] q_word;
  pwsu_ctl_t            q_ctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bits_per_sample  <= BPS_RESET;
      cfg.pad_mode         <= 1'b0;
      cfg.samples_per_line <= SPL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BITS_PER_SAMPLE:  cfg.bits_per_sample  <= cfg_data[BPS_W-1:0];
        REG_PAD_MODE:         cfg.pad_mode         <= cfg_data[0];
        REG_SAMPLES_PER_LINE: cfg.samples_per_line <= cfg_data[SPL_W-1:0];
        default:              cfg                  <= cfg;
      endcase
    end
  end

  pwsu_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .packed_word (packed_word),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_word      (q_word),
    .q_ctl       (q_ctl)
  );

  pwsu_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_word       (q_word),
    .q_ctl        (q_ctl),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_value (sample_value),
    .last_of_word (last_of_word),
    .end_of_line  (end_of_line)
  );

endmodule
